// ===== hdl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step block: request
// payloads, configuration register indexes, rule counts and memory control.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Input request: load one row or emit the board and advance
    typedef struct packed {
        logic        mode;
        logic [3:0]  row_index;
        logic [31:0] row_bits;
    } lgs_in_t;

    // Result request: one emitted row of the pre-step board
    typedef struct packed {
        logic [3:0]  out_row;
        logic [31:0] out_bits;
        logic        last_row;
    } lgs_out_t;

    // Control from the sequencer to the board memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic trim;
    } lgs_mem_ctl_t;

    // Request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 4'd1;

    localparam logic [4:0] ACTIVE_ROWS_RESET = 5'd10;
    localparam logic [5:0] ACTIVE_COLS_RESET = 6'd20;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

// ===== hdl/lgs_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_cell
// One column lane of the rule engine: counts the eight neighbors in a 3x3
// window and applies the birth and survival rule to the center cell.
// ----------------------------------------------------------------------------
module lgs_cell (
    input  logic [2:0] above,
    input  logic [2:0] mid,
    input  logic [2:0] below,
    output logic       next_state
);
    import lgs_pkg::*;

    logic [3:0] count;

    // Sum the eight neighbors, center excluded
    assign count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
                 + 4'(mid[0])   + 4'(mid[2])
                 + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

    // Birth on three, survival on two or three
    assign next_state = (count == BIRTH_COUNT) || (mid[1] && (count == SURVIVE_COUNT));

endmodule

// ===== hdl/lgs_board.sv =====
// ----------------------------------------------------------------------------
// lgs_board
// Board storage: one row per entry, one write port and one registered read
// port. A valid bit per row makes unwritten or trimmed rows read as dead.
// ----------------------------------------------------------------------------
module lgs_board #(
    parameter int unsigned ROWS = 16,
    parameter int unsigned COLS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lgs_pkg::lgs_mem_ctl_t           ctl,
    input  logic [$clog2(ROWS)-1:0]         waddr,
    input  logic [COLS-1:0]                 wdata,
    input  logic [$clog2(ROWS)-1:0]         raddr,
    input  logic [$clog2(ROWS+2)-1:0]       rows_lim,
    output logic [COLS-1:0]                 rdata
);
    import lgs_pkg::*;

    localparam int unsigned TW = $clog2(ROWS + 2);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_data_reg;
    logic            rd_valid_reg;
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;

    // Write and read the row array
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Mark written rows valid; drop rows past the active area on trim
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr_en)
        begin
            valid_next[waddr] = 1'b1;
        end
        if (ctl.trim)
        begin
            for (int y = 0; y < ROWS; y++)
            begin
                if (TW'(y) >= rows_lim)
                begin
                    valid_next[y] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/life_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_generation_step
// B3/S23 life on a bounded, non-wrapping board held as row words. A load
// request writes one row; a step request emits every active row and replaces
// the board with its next generation, one row per cycle while the output is
// not stalled, through a three-row window and one rule lane per column.
//
//   channel | signals                          | direction | payload
//   --------+----------------------------------+-----------+------------------
//   in      | in_valid, in_stall, in_data      | to block  | lgs_in_t
//   out     | out_valid, out_stall, out_data   | from block| lgs_out_t
//   cfg     | cfg_valid, cfg_ready, cfg_index, | to block  | index, data
//           | cfg_data                         |           |
//
// A load request is taken while idle. A step request keeps in_stall high from
// acceptance until its final slot: one board row is read per cycle from the
// single read port of the board memory while the output does not stall, and
// the window fills before the first row is emitted.
// Reset leaves every cell dead through per-row valid bits; no clearing pass.
// Output stall freezes the whole row pipeline; in_stall is high during a step.
// ----------------------------------------------------------------------------
module life_generation_step #(
    parameter int unsigned ROWS = 16,
    parameter int unsigned COLS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lgs_pkg::lgs_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lgs_pkg::lgs_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lgs_pkg::*;

    localparam int unsigned AW = $clog2(ROWS);
    localparam int unsigned TW = $clog2(ROWS + 2);
    localparam logic [7:0] ROWS8 = 8'(ROWS);
    localparam logic [7:0] COLS8 = 8'(COLS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [TW-1:0]   t_reg, t_next;
    logic [4:0]      active_rows_reg;
    logic [5:0]      active_cols_reg;
    logic [COLS-1:0] prev1_reg;
    logic [COLS-1:0] prev2_reg;
    logic            out_valid_reg, out_valid_next;
    lgs_out_t        out_data_reg;

    logic [7:0]      rows8;
    logic [7:0]      cols8;
    logic [TW-1:0]   rows_eff;
    logic [TW-1:0]   last_t;
    logic [COLS-1:0] cmask;
    logic            accept;
    logic            advance;
    logic            emit;
    logic [7:0]      t8;
    logic [7:0]      ctr8;
    logic [7:0]      idx8;
    logic [127:0]    load_wide;
    logic            load_hit;
    logic [COLS-1:0] rdata;
    logic [COLS-1:0] in_word;
    logic [COLS+1:0] pad_above;
    logic [COLS+1:0] pad_mid;
    logic [COLS+1:0] pad_below;
    logic [COLS-1:0] lane_next;
    logic [COLS-1:0] new_row;
    logic [127:0]    out_wide;
    lgs_mem_ctl_t    mem_ctl;
    logic [AW-1:0]   waddr;
    logic [COLS-1:0] wdata;

    // Clamp the active area to the board
    always_comb
    begin
        rows8 = {3'b000, active_rows_reg};
        if (rows8 == 8'd0)
        begin
            rows8 = 8'd1;
        end
        else if (rows8 > ROWS8)
        begin
            rows8 = ROWS8;
        end
        cols8 = {2'b00, active_cols_reg};
        if (cols8 == 8'd0)
        begin
            cols8 = 8'd1;
        end
        else if (cols8 > COLS8)
        begin
            cols8 = COLS8;
        end
    end

    assign rows_eff = rows8[TW-1:0];
    assign last_t   = rows_eff + TW'(1);

    // Column mask of the active area
    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            cmask[c] = (8'(c) < cols8);
        end
    end

    // Handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign advance   = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);
    assign emit      = advance && (t_reg >= TW'(2));
    assign cfg_ready = 1'b1;

    // Row counters: t is the read slot, the center row lags it by two
    assign t8   = {{(8 - TW){1'b0}}, t_reg};
    assign ctr8 = t8 - 8'd2;
    assign idx8 = {4'b0000, in_data.row_index};

    // Load path
    assign load_wide = {96'd0, in_data.row_bits};
    assign load_hit  = accept && (in_data.mode == MODE_LOAD) && (idx8 < ROWS8);

    // Sequence the step
    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.mode == MODE_STEP))
                begin
                    state_next = ST_RUN;
                    t_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    t_next = t_reg + TW'(1);
                    if (t_reg == last_t)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            t_reg           <= '0;
            out_valid_reg   <= 1'b0;
            active_rows_reg <= ACTIVE_ROWS_RESET;
            active_cols_reg <= ACTIVE_COLS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ACTIVE_ROWS: active_rows_reg <= cfg_data[4:0];
                    REG_ACTIVE_COLS: active_cols_reg <= cfg_data[5:0];
                    default:         ;
                endcase
            end
        end
    end

    // Incoming row, dead outside the active area
    assign in_word = (t_reg <= rows_eff) ? (rdata & cmask) : '0;

    // Advance the three-row window
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (t_reg == '0)
            begin
                prev1_reg <= '0;
            end
            else
            begin
                prev2_reg <= prev1_reg;
                prev1_reg <= in_word;
            end
        end
    end

    // One rule lane per column
    assign pad_above = {1'b0, prev2_reg, 1'b0};
    assign pad_mid   = {1'b0, prev1_reg, 1'b0};
    assign pad_below = {1'b0, in_word, 1'b0};

    for (genvar c = 0; c < COLS; c++)
    begin : g_lane
        lgs_cell u_cell (
            .above      (pad_above[c+2:c]),
            .mid        (pad_mid[c+2:c]),
            .below      (pad_below[c+2:c]),
            .next_state (lane_next[c])
        );
    end

    // Merge the lanes into the next-generation row
    assign new_row = lane_next & cmask;

    // Load the result register with the pre-step row
    assign out_wide = {{(128 - COLS){1'b0}}, prev1_reg};

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.out_row  <= ctr8[3:0];
            out_data_reg.out_bits <= out_wide[31:0];
            out_data_reg.last_row <= (t_reg == last_t);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Drive the board port: step writes back while running, loads otherwise
    always_comb
    begin
        mem_ctl.rd_en = advance && (t_reg < rows_eff);
        mem_ctl.trim  = advance && (t_reg == last_t);
        if (state_reg == ST_RUN)
        begin
            mem_ctl.wr_en = emit;
            waddr         = ctr8[AW-1:0];
            wdata         = new_row;
        end
        else
        begin
            mem_ctl.wr_en = load_hit;
            waddr         = idx8[AW-1:0];
            wdata         = load_wide[COLS-1:0];
        end
    end

    lgs_board #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_board (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr    (t_reg[AW-1:0]),
        .rows_lim (rows_eff),
        .rdata    (rdata)
    );

    // The final slot of a step returns the sequencer to idle
    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (t_reg == last_t)) |=> (state_reg == ST_IDLE))
        else $error("step did not end after the final row");

    // The final slot leaves a result marked last
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (t_reg == last_t)) |=> (out_valid && out_data.last_row))
        else $error("final row not marked last");

    // Write-back stays inside the active rows
    a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && mem_ctl.wr_en) |-> (ctr8 < rows8))
        else $error("write-back outside active rows");

    // The slot counter never runs past the final slot
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (t_reg <= last_t))
        else $error("slot counter overran");

endmodule

// ===== verif/life_generation_step_tb.sv =====
// ----------------------------------------------------------------------------
// life_generation_step_tb
// Self-checking bench for the B3/S23 life block. An initial block queues load
// and step requests in phases, with register writes while the block is idle.
// A clocked driver sends them in bursts and updates a board predictor on each
// accepted request. A clocked monitor checks every emitted row against the
// oldest predicted row. The output stall follows its own changing pattern.
// ----------------------------------------------------------------------------
module life_generation_step_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int GRID_ROWS    = 16;
    localparam int GRID_COLS    = 32;
    localparam int DRAIN_CYCLES = GRID_ROWS + 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 500000;

    // Index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    lgs_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    lgs_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: board and register shadows
    logic [GRID_COLS-1:0] board_model [GRID_ROWS];
    logic [4:0]           rows_cfg = ACTIVE_ROWS_RESET;
    logic [5:0]           cols_cfg = ACTIVE_COLS_RESET;

    lgs_in_t     request_backlog [$];
    lgs_out_t    emitted_rows_due [$];
    int unsigned queued_cnt     = 0;
    int unsigned accepted_cnt   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Sender and receiver pacing
    logic        sender_eager = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_span   = 0;
    int          stall_style  = 0;

    life_generation_step #(
        .ROWS (GRID_ROWS),
        .COLS (GRID_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Clamp the register values to the usable grid
    function automatic int eff_rows();
        if (rows_cfg == 0)
            return 1;
        if (rows_cfg > GRID_ROWS)
            return GRID_ROWS;
        return int'(rows_cfg);
    endfunction

    function automatic int eff_cols();
        if (cols_cfg == 0)
            return 1;
        if (cols_cfg > GRID_COLS)
            return GRID_COLS;
        return int'(cols_cfg);
    endfunction

    // Apply one accepted request to the board; a step queues the rows it emits
    function automatic void model_request(input lgs_in_t req);
        int n_rows;
        int n_cols;
        int nb;
        int yy;
        int xx;
        logic [GRID_COLS-1:0] col_mask;
        logic [GRID_COLS-1:0] cur [GRID_ROWS];
        logic [GRID_COLS-1:0] nxt [GRID_ROWS];
        lgs_out_t emitted;

        if (req.mode == MODE_LOAD)
        begin
            board_model[req.row_index] = req.row_bits;
            return;
        end

        n_rows = eff_rows();
        n_cols = eff_cols();
        col_mask = (n_cols >= GRID_COLS) ? '1 : ((32'd1 << n_cols) - 32'd1);

        // Cells outside the active area read as dead
        for (int y = 0; y < GRID_ROWS; y++)
            cur[y] = (y < n_rows) ? (board_model[y] & col_mask) : '0;

        // Emit the pre-step board, last flag on the final active row
        for (int y = 0; y < n_rows; y++)
        begin
            emitted.out_row  = 4'(y);
            emitted.out_bits = cur[y];
            emitted.last_row = (y + 1 == n_rows);
            emitted_rows_due.push_back(emitted);
        end

        // Next generation: survive on two or three, birth on three
        for (int y = 0; y < GRID_ROWS; y++)
        begin
            nxt[y] = '0;
            if (y < n_rows)
            begin
                for (int c = 0; c < n_cols; c++)
                begin
                    nb = 0;
                    for (int dy = -1; dy <= 1; dy++)
                    begin
                        for (int dx = -1; dx <= 1; dx++)
                        begin
                            yy = y + dy;
                            xx = c + dx;
                            if ((dy != 0 || dx != 0) && yy >= 0 && yy < n_rows &&
                                xx >= 0 && xx < n_cols)
                                nb += int'(cur[yy][xx]);
                        end
                    end
                    if (cur[y][c] ? (nb == SURVIVE_COUNT || nb == BIRTH_COUNT)
                                  : (nb == BIRTH_COUNT))
                        nxt[y][c] = 1'b1;
                end
            end
        end

        for (int y = 0; y < GRID_ROWS; y++)
            board_model[y] = nxt[y];
    endfunction

    // Shadow the configuration registers on each accepted write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg = ACTIVE_ROWS_RESET;
            cols_cfg = ACTIVE_COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVE_ROWS: rows_cfg = cfg_data[4:0];
                REG_ACTIVE_COLS: cols_cfg = cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Driver: predict on acceptance, then present the next request or a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            for (int y = 0; y < GRID_ROWS; y++)
                board_model[y] = '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                model_request(in_data);
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    in_data  <= request_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = sender_eager ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: switch between free flow, light, heavy and run stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_span == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_span  = $urandom_range(16, 64);
            end
            else
                stall_span--;
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((stall_span % 12) < 5);
            endcase
        end
    end

    // Monitor: check each accepted row against the oldest expectation
    always @(posedge clk)
    begin
        lgs_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (emitted_rows_due.size() == 0)
            begin
                $display("%0t: unexpected row result: expected none, actual row %0d bits %h last %0b",
                         $time, out_data.out_row, out_data.out_bits, out_data.last_row);
                mismatch_count++;
            end
            else
            begin
                want = emitted_rows_due.pop_front();
                if (out_data.out_row !== want.out_row)
                begin
                    $display("%0t: out_row expected %0d actual %0d",
                             $time, want.out_row, out_data.out_row);
                    mismatch_count++;
                end
                if (out_data.out_bits !== want.out_bits)
                begin
                    $display("%0t: out_bits of row %0d expected %h actual %h",
                             $time, want.out_row, want.out_bits, out_data.out_bits);
                    mismatch_count++;
                end
                if (out_data.last_row !== want.last_row)
                begin
                    $display("%0t: last_row of row %0d expected %0b actual %0b",
                             $time, want.out_row, want.last_row, out_data.last_row);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic queue_request(input logic mode, input logic [3:0] idx,
                                 input logic [31:0] bits);
        lgs_in_t req;
        req.mode      = mode;
        req.row_index = idx;
        req.row_bits  = bits;
        request_backlog.push_back(req);
        queued_cnt++;
    endtask

    // Wait until every request is taken and every row is out, then let it drain
    task automatic settle();
        while (!(accepted_cnt == queued_cnt && emitted_rows_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Row contents from empty through sparse and dense to full
    function automatic logic [31:0] random_row_bits();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom & $urandom;
            2:       return $urandom | $urandom;
            3:       return 32'h7 << $urandom_range(0, 29);
            4:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int unsigned n_items;
        int unsigned pick;
        logic [3:0]  idx;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: full rows, edge blocks, rows beyond the active area
        queue_request(MODE_LOAD, 4'd0, 32'hFFFF_FFFF);
        queue_request(MODE_LOAD, 4'd15, 32'hFFFF_FFFF);
        queue_request(MODE_LOAD, 4'd1, 32'h0000_0000);
        queue_request(MODE_LOAD, 4'd3, 32'h0000_00E0);
        queue_request(MODE_LOAD, 4'd7, 32'h000C_0003);
        queue_request(MODE_LOAD, 4'd8, 32'h000C_0003);
        queue_request(MODE_LOAD, 4'd9, 32'h5555_5555);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        queue_request(MODE_STEP, 4'd15, 32'hFFFF_FFFF);
        queue_request(MODE_STEP, 4'd5, 32'h1234_5678);
        settle();

        // Largest grid: stale cells must have been cleared by the steps
        write_reg(REG_ACTIVE_ROWS, 8'd16);
        write_reg(REG_ACTIVE_COLS, 8'd32);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        queue_request(MODE_LOAD, 4'd15, 32'h8000_0001);
        queue_request(MODE_LOAD, 4'd14, 32'hFFFF_FFFF);
        queue_request(MODE_LOAD, 4'd0, 32'hAAAA_AAAA);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        settle();

        // Zero registers act as a one-cell grid
        write_reg(REG_ACTIVE_ROWS, 8'd0);
        write_reg(REG_ACTIVE_COLS, 8'd0);
        queue_request(MODE_LOAD, 4'd0, 32'hFFFF_FFFF);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        settle();

        // Oversized registers clamp to the grid; unknown index is dropped
        write_reg(REG_ACTIVE_ROWS, 8'hFF);
        write_reg(REG_ACTIVE_COLS, 8'hFF);
        write_reg(REG_SPARE, 8'h01);
        queue_request(MODE_LOAD, 4'd1, 32'h0000_0002);
        queue_request(MODE_LOAD, 4'd2, 32'h0000_0004);
        queue_request(MODE_LOAD, 4'd3, 32'h0000_0007);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        queue_request(MODE_STEP, 4'd0, 32'h0);
        settle();

        // Random phases: reconfigure, load a board, run a few generations
        n_items = queued_cnt + RANDOM_ITEMS;
        while (queued_cnt < n_items)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       pick = 0;
                        1:       pick = 1;
                        2:       pick = GRID_ROWS;
                        3:       pick = $urandom_range(GRID_ROWS + 1, 31);
                        default: pick = $urandom_range(2, GRID_ROWS - 1);
                    endcase
                    write_reg(REG_ACTIVE_ROWS, {3'($urandom), 5'(pick)});
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       pick = 0;
                        1:       pick = 1;
                        2:       pick = GRID_COLS;
                        3:       pick = $urandom_range(GRID_COLS + 1, 63);
                        default: pick = $urandom_range(2, GRID_COLS - 1);
                    endcase
                    write_reg(REG_ACTIVE_COLS, {2'($urandom), 6'(pick)});
                end
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
            end

            sender_eager = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 9) < 8)
            begin
                // Well-formed: fill some active rows, then advance
                repeat ($urandom_range(1, eff_rows()))
                begin
                    if ($urandom_range(0, 9) < 8)
                        idx = 4'($urandom_range(0, eff_rows() - 1));
                    else
                        idx = 4'($urandom_range(0, 15));
                    queue_request(MODE_LOAD, idx, random_row_bits());
                    if ($urandom_range(0, 9) == 0)
                        queue_request(MODE_STEP, 4'($urandom), $urandom);
                end
                repeat ($urandom_range(1, 4))
                    queue_request(MODE_STEP, 4'($urandom), $urandom);
            end
            else
            begin
                // Noise: any mode, any row, any bits
                repeat ($urandom_range(3, 10))
                    queue_request(($urandom_range(0, 1) == 1) ? MODE_STEP : MODE_LOAD,
                                  4'($urandom), $urandom);
            end

            // Hold off until the block is empty before the next phase
            settle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
